// File: sv/hmbp_pkg.sv
`default_nettype none
package hmbp_pkg;

  localparam int MAX_CODE_LEN_DEF = 24;
  localparam int SYMBOLS_DEF      = 256;

  localparam int CODE_W  = 24;
  localparam int LEN_W   = 5;
  localparam int INDEX_W = 16;

  // A result list holds a flush byte, an index and up to four packed bytes.
  localparam int BYTES_MAX  = 4;
  localparam int SLOTS      = 2 + BYTES_MAX;
  localparam int SLOT_FLUSH = 0;
  localparam int SLOT_INDEX = 1;
  localparam int SLOT_BYTE0 = 2;

  localparam logic [7:0] NEWLINE = 8'h0A;

  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_INDEX = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_END    = 2'd2
  } op_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } entry_t;

  typedef struct packed {
    logic is_end;
    logic sym_zero;
    logic in_range;
  } item_t;

  typedef struct packed {
    logic [SLOTS-1:0]          mask;
    logic [7:0]                flush_byte;
    logic [INDEX_W-1:0]        index;
    logic                      wrap;
    logic [BYTES_MAX-1:0][7:0] bytes;
  } job_t;

endpackage
`default_nettype wire

// File: sv/hmbp_if.sv
`default_nettype none
interface hmbp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  symbol;
  logic [23:0] code_bits;
  logic [4:0]  code_length;

  modport source (output valid, output op, output symbol, output code_bits,
                  output code_length, input ready);
  modport sink (input valid, input op, input symbol, input code_bits,
                input code_length, output ready);
endinterface

interface hmbp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] data;
  logic        wrapped;
  logic        last;

  modport source (output valid, output kind, output data, output wrapped,
                  output last, input ready);
  modport sink (input valid, input kind, input data, input wrapped,
                input last, output ready);
endinterface
`default_nettype wire

// File: sv/hmbp_table.sv
`default_nettype none
module hmbp_table #(
  parameter int SYMBOLS = hmbp_pkg::SYMBOLS_DEF,
  parameter int AW      = $clog2(SYMBOLS)
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire hmbp_pkg::entry_t      wdata,
  input  wire logic                  re,
  input  wire logic [AW-1:0]         raddr,
  output hmbp_pkg::entry_t           rdata
);

  hmbp_pkg::entry_t mem [SYMBOLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: sv/hmbp_pack.sv
`default_nettype none
module hmbp_pack (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  input  wire hmbp_pkg::item_t   item,
  output logic                   ready,
  input  wire hmbp_pkg::entry_t  rdata,
  output logic                   job_valid,
  output hmbp_pkg::job_t         job,
  input  wire logic              job_ready
);

  logic                              s1_valid;
  hmbp_pkg::item_t                   s1_item;
  logic [7:0]                        pending_byte;
  logic [2:0]                        bits_filled;
  logic [hmbp_pkg::INDEX_W-1:0]      byte_offset;
  logic                              message_start;
  logic [hmbp_pkg::INDEX_W-1:0]      previous_index;
  logic                              have_previous;

  logic                              enc;
  logic                              flush_v;
  logic                              idx_v;
  logic [2:0]                        fill0;
  logic [7:0]                        pend0;
  logic [hmbp_pkg::LEN_W-1:0]        len_eff;
  logic [5:0]                        shamt;
  logic [31:0]                       codeword;
  logic [39:0]                       win;
  logic [39:0]                       rest;
  logic [5:0]                        total;
  logic [2:0]                        nbytes;
  logic [hmbp_pkg::INDEX_W-1:0]      off1;
  logic                              fire;

  always_comb begin
    enc     = !s1_item.is_end;
    flush_v = (s1_item.is_end || message_start) && (bits_filled != 3'd0);
    idx_v   = enc && message_start;
    fill0   = flush_v ? 3'd0 : bits_filled;
    pend0   = flush_v ? 8'd0 : pending_byte;
    len_eff = (enc && s1_item.in_range) ? rdata.len : '0;
    // Left-align the code in a 32-bit word; bits above the length fall off.
    shamt    = 6'd32 - {1'b0, len_eff};
    codeword = {8'd0, rdata.code} << shamt;
    win      = {pend0, 32'd0} | ({codeword, 8'd0} >> fill0);
    total    = {3'd0, fill0} + {1'b0, len_eff};
    nbytes   = total[5:3];
    rest     = win << {nbytes, 3'd0};
    off1     = byte_offset + hmbp_pkg::INDEX_W'(flush_v);

    job.flush_byte = pending_byte;
    job.index      = off1;
    job.wrap       = have_previous && (off1 < previous_index);
    for (int k = 0; k < hmbp_pkg::BYTES_MAX; k++) begin
      job.bytes[k] = win[39 - 8*k -: 8];
      job.mask[hmbp_pkg::SLOT_BYTE0 + k] = (3'(k) < nbytes);
    end
    job.mask[hmbp_pkg::SLOT_FLUSH] = flush_v;
    job.mask[hmbp_pkg::SLOT_INDEX] = idx_v;

    job_valid = s1_valid && (job.mask != '0);
    fire      = s1_valid && (job_ready || (job.mask == '0));
    ready     = !s1_valid || fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      pending_byte   <= 8'd0;
      bits_filled    <= 3'd0;
      byte_offset    <= '0;
      message_start  <= 1'b1;
      previous_index <= '0;
      have_previous  <= 1'b0;
    end else begin
      if (item_valid && ready) begin
        s1_valid <= 1'b1;
      end else if (fire) begin
        s1_valid <= 1'b0;
      end
      if (fire) begin
        pending_byte  <= rest[39:32];
        bits_filled   <= total[2:0];
        byte_offset   <= off1 + hmbp_pkg::INDEX_W'(nbytes);
        message_start <= s1_item.is_end || s1_item.sym_zero;
        if (idx_v) begin
          previous_index <= off1;
          have_previous  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && ready) begin
      s1_item <= item;
    end
  end

endmodule
`default_nettype wire

// File: sv/hmbp_emit.sv
`default_nettype none
module hmbp_emit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            job_valid,
  input  wire hmbp_pkg::job_t  job_in,
  output logic                 job_ready,
  hmbp_out_if.source           results
);

  hmbp_pkg::job_t                  job;
  logic [hmbp_pkg::SLOTS-1:0]      mask;
  logic [hmbp_pkg::SLOTS-1:0]      lowest;
  logic [hmbp_pkg::SLOTS-1:0]      rest;
  logic                            fire;

  always_comb begin
    lowest = mask & (~mask + hmbp_pkg::SLOTS'(1));
    rest   = mask & ~lowest;
    results.valid   = (mask != '0);
    results.last    = (rest == '0);
    results.kind    = hmbp_pkg::KIND_BYTE;
    results.wrapped = 1'b0;
    results.data    = {8'd0, job.flush_byte};
    if (lowest[hmbp_pkg::SLOT_INDEX]) begin
      results.kind    = hmbp_pkg::KIND_INDEX;
      results.wrapped = job.wrap;
      results.data    = job.index;
    end
    for (int k = 0; k < hmbp_pkg::BYTES_MAX; k++) begin
      if (lowest[hmbp_pkg::SLOT_BYTE0 + k]) begin
        results.data = {8'd0, job.bytes[k]};
      end
    end
    fire      = results.valid && results.ready;
    job_ready = (mask == '0) || (fire && results.last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (job_valid && job_ready) begin
      mask <= job_in.mask;
    end else if (fire) begin
      mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      job <= job_in;
    end
  end

endmodule
`default_nettype wire

// File: sv/huffman_message_bit_packer_core.sv
`default_nettype none
// Channel   Dir  Payload                                  Request
// items     in   op, symbol, code_bits, code_length       load, encode or end of stream
// results   out  kind, data, wrapped, last                packed byte or message index
//
// An encode request reads the code table at acceptance and is packed in the
// following cycle; each result then takes its own output transfer, so an item
// with one result sustains one request per cycle while the output is ready,
// and an item with n results makes n output transfers. The output, one result
// a cycle when ready, sets the pace. Reset clears the packing state; the code
// table is not cleared and must be loaded before use. A stalled output holds
// one result list and one packed request, after which the input stalls.
module huffman_message_bit_packer_core #(
  parameter int MAX_CODE_LEN = hmbp_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOLS      = hmbp_pkg::SYMBOLS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  hmbp_in_if.sink     items,
  hmbp_out_if.source  results
);

  localparam int AW = $clog2(SYMBOLS);

  logic              accept;
  logic [7:0]        sym;
  logic              in_range;
  logic              pack_ready;
  logic              item_valid;
  hmbp_pkg::item_t   item;
  hmbp_pkg::entry_t  wdata;
  hmbp_pkg::entry_t  rdata;
  logic              we;
  logic              re;
  logic              job_valid;
  logic              job_ready;
  hmbp_pkg::job_t    job;

  always_comb begin
    items.ready = pack_ready;
    accept      = items.valid && pack_ready;
    // Newline is encoded as the message terminator.
    sym         = (items.symbol == hmbp_pkg::NEWLINE) ? 8'd0 : items.symbol;
    in_range    = ({1'b0, sym} < 9'(SYMBOLS));
    wdata.code  = items.code_bits;
    wdata.len   = ({1'b0, items.code_length} > 6'(MAX_CODE_LEN)) ?
                  hmbp_pkg::LEN_W'(MAX_CODE_LEN) : items.code_length;
    we          = accept && (items.op == hmbp_pkg::OP_LOAD) &&
                  ({1'b0, items.symbol} < 9'(SYMBOLS));
    re          = accept && (items.op == hmbp_pkg::OP_ENCODE);
    item_valid  = accept && ((items.op == hmbp_pkg::OP_ENCODE) ||
                             (items.op == hmbp_pkg::OP_END));
    item.is_end   = (items.op == hmbp_pkg::OP_END);
    item.sym_zero = (sym == 8'd0);
    item.in_range = in_range;
  end

  hmbp_table #(
    .SYMBOLS (SYMBOLS),
    .AW      (AW)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (items.symbol[AW-1:0]),
    .wdata (wdata),
    .re    (re),
    .raddr (sym[AW-1:0]),
    .rdata (rdata)
  );

  hmbp_pack u_pack (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .ready      (pack_ready),
    .rdata      (rdata),
    .job_valid  (job_valid),
    .job        (job),
    .job_ready  (job_ready)
  );

  hmbp_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_in    (job),
    .job_ready (job_ready),
    .results   (results)
  );

endmodule
`default_nettype wire
